// File: hw/rtl/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

  // Field widths and fixed-point format.
  localparam int VecW  = 16;
  localparam int QW    = 16;
  localparam int FracW = 14;
  localparam int TW    = 20;
  localparam int OutW  = 18;
  localparam int P1W   = VecW + QW;
  localparam int S1W   = P1W + 2;
  localparam int P2W   = TW + QW;
  localparam int S2W   = P2W + 3;
  localparam int RndW  = S2W - FracW;
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Rotation quaternion, each component signed Q1.14.
  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  // Intermediate product q * p, rounded to integer scale.
  typedef struct packed {
    logic signed [TW-1:0] s;
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
  } tquat_t;

  // Register map.
  typedef enum logic [1:0] {
    REG_W = 2'd0,
    REG_X = 2'd1,
    REG_Y = 2'd2,
    REG_Z = 2'd3
  } reg_idx_t;

  localparam logic signed [QW-1:0] ROT_W_RST = 16'sd16384;
  localparam logic signed [QW-1:0] ROT_V_RST = 16'sd0;

  // Clamp a rounded result to the signed output range.
  function automatic logic signed [OutW-1:0] sat_out(input logic signed [RndW-1:0] a);
    logic signed [RndW-1:0] hi;
    logic signed [RndW-1:0] lo;
    hi = RndW'(131071);
    lo = -RndW'(131072);
    if (a > hi) begin
      return OutW'(131071);
    end else if (a < lo) begin
      return OutW'(-131072);
    end
    return a[OutW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qvr_cfg.sv
`default_nettype none

module qvr_cfg import qvr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output quat_t                 rot
);

  quat_t    rot_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign rot    = rot_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r.w <= ROT_W_RST;
      rot_r.x <= ROT_V_RST;
      rot_r.y <= ROT_V_RST;
      rot_r.z <= ROT_V_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_W:   rot_r.w <= pwdata[QW-1:0];
        REG_X:   rot_r.x <= pwdata[QW-1:0];
        REG_Y:   rot_r.y <= pwdata[QW-1:0];
        REG_Z:   rot_r.z <= pwdata[QW-1:0];
        default: rot_r   <= rot_r;
      endcase
    end
  end

  // Read data is the register sign-extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_W:   prdata = DataW'(rot_r.w);
      REG_X:   prdata = DataW'(rot_r.x);
      REG_Y:   prdata = DataW'(rot_r.y);
      REG_Z:   prdata = DataW'(rot_r.z);
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/qvr_qmul1.sv
`default_nettype none

module qvr_qmul1 import qvr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   valid_in,
  input  wire logic signed [VecW-1:0] vx,
  input  wire logic signed [VecW-1:0] vy,
  input  wire logic signed [VecW-1:0] vz,
  input  wire quat_t                  rot,
  output logic                        valid_out,
  output tquat_t                      t_out
);

  logic signed [P1W-1:0] prod_nxt [12];
  logic signed [P1W-1:0] prod_r   [12];
  logic                  pv_r;
  logic signed [S1W-1:0] ss, sx, sy, sz;
  tquat_t                t_nxt, t_r;
  logic                  tv_r;

  // Stage one: the twelve products of q * (0; v).
  always_comb begin
    prod_nxt[0]  = P1W'(rot.x * vx);
    prod_nxt[1]  = P1W'(rot.y * vy);
    prod_nxt[2]  = P1W'(rot.z * vz);
    prod_nxt[3]  = P1W'(rot.w * vx);
    prod_nxt[4]  = P1W'(rot.y * vz);
    prod_nxt[5]  = P1W'(rot.z * vy);
    prod_nxt[6]  = P1W'(rot.w * vy);
    prod_nxt[7]  = P1W'(rot.z * vx);
    prod_nxt[8]  = P1W'(rot.x * vz);
    prod_nxt[9]  = P1W'(rot.w * vz);
    prod_nxt[10] = P1W'(rot.x * vy);
    prod_nxt[11] = P1W'(rot.y * vx);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage two: sums with the half-LSB rounding term, then a floor shift.
  always_comb begin
    ss = S1W'(1 << (FracW - 1)) - S1W'(prod_r[0]) - S1W'(prod_r[1]) - S1W'(prod_r[2]);
    sx = S1W'(1 << (FracW - 1)) + S1W'(prod_r[3]) + S1W'(prod_r[4]) - S1W'(prod_r[5]);
    sy = S1W'(1 << (FracW - 1)) + S1W'(prod_r[6]) + S1W'(prod_r[7]) - S1W'(prod_r[8]);
    sz = S1W'(1 << (FracW - 1)) + S1W'(prod_r[9]) + S1W'(prod_r[10]) - S1W'(prod_r[11]);
    t_nxt.s = ss[S1W-1:FracW];
    t_nxt.x = sx[S1W-1:FracW];
    t_nxt.y = sy[S1W-1:FracW];
    t_nxt.z = sz[S1W-1:FracW];
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      tv_r <= 1'b0;
    end else begin
      pv_r <= valid_in;
      tv_r <= pv_r;
    end
  end

  assign valid_out = tv_r;
  assign t_out     = t_r;

endmodule

`default_nettype wire

// File: hw/rtl/qvr_qmul2.sv
`default_nettype none

module qvr_qmul2 import qvr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   valid_in,
  input  wire tquat_t                 t_in,
  input  wire quat_t                  rot,
  output logic                        valid_out,
  output logic signed [OutW-1:0]      rx,
  output logic signed [OutW-1:0]      ry,
  output logic signed [OutW-1:0]      rz
);

  logic signed [P2W-1:0]  prod_nxt [12];
  logic signed [P2W-1:0]  prod_r   [12];
  logic                   pv_r;
  logic signed [S2W-1:0]  sx, sy, sz;
  logic signed [OutW-1:0] rx_nxt, ry_nxt, rz_nxt;
  logic signed [OutW-1:0] rx_r, ry_r, rz_r;
  logic                   ov_r;

  // Stage three: the products of t * conj(q), vector part only.
  always_comb begin
    prod_nxt[0]  = P2W'(t_in.s * rot.x);
    prod_nxt[1]  = P2W'(t_in.s * rot.y);
    prod_nxt[2]  = P2W'(t_in.s * rot.z);
    prod_nxt[3]  = P2W'(rot.w * t_in.x);
    prod_nxt[4]  = P2W'(rot.w * t_in.y);
    prod_nxt[5]  = P2W'(rot.w * t_in.z);
    prod_nxt[6]  = P2W'(t_in.y * rot.z);
    prod_nxt[7]  = P2W'(t_in.z * rot.y);
    prod_nxt[8]  = P2W'(t_in.z * rot.x);
    prod_nxt[9]  = P2W'(t_in.x * rot.z);
    prod_nxt[10] = P2W'(t_in.x * rot.y);
    prod_nxt[11] = P2W'(t_in.y * rot.x);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage four: sums, round half up, then clamp to the output range.
  always_comb begin
    sx = S2W'(1 << (FracW - 1)) - S2W'(prod_r[0]) + S2W'(prod_r[3])
         - S2W'(prod_r[6]) + S2W'(prod_r[7]);
    sy = S2W'(1 << (FracW - 1)) - S2W'(prod_r[1]) + S2W'(prod_r[4])
         - S2W'(prod_r[8]) + S2W'(prod_r[9]);
    sz = S2W'(1 << (FracW - 1)) - S2W'(prod_r[2]) + S2W'(prod_r[5])
         - S2W'(prod_r[10]) + S2W'(prod_r[11]);
    rx_nxt = sat_out(sx[S2W-1:FracW]);
    ry_nxt = sat_out(sy[S2W-1:FracW]);
    rz_nxt = sat_out(sz[S2W-1:FracW]);
  end

  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    rz_r <= rz_nxt;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      pv_r <= valid_in;
      ov_r <= pv_r;
    end
  end

  assign valid_out = ov_r;
  assign rx        = rx_r;
  assign ry        = ry_r;
  assign rz        = rz_r;

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_vector_rotation.sv
// Each accepted request passes through four register stages before its result appears.
// Throughput: one request per cycle; busy stays low, and the output cannot be stalled.
// The four stages are two multiply stages and two sum-round stages of the two products.
// Reset (synchronous, active low) clears the valid bits and sets the quaternion to identity.
`default_nettype none

module quaternion_vector_rotation import qvr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [AddrW-1:0]       paddr,
  input  wire logic [DataW-1:0]       pwdata,
  output logic      [DataW-1:0]       prdata,
  output logic                        pready,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [VecW-1:0] in_vec_x,
  input  wire logic signed [VecW-1:0] in_vec_y,
  input  wire logic signed [VecW-1:0] in_vec_z,
  output logic                        out_valid,
  output logic signed [OutW-1:0]      out_x,
  output logic signed [OutW-1:0]      out_y,
  output logic signed [OutW-1:0]      out_z
);

  quat_t  rot;
  tquat_t t_mid;
  logic   t_valid;
  logic   accept;

  // The pipeline never stalls, so a request is always taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  qvr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rot     (rot)
  );

  // First product t = q * (0; v).
  qvr_qmul1 u_qmul1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (accept),
    .vx        (in_vec_x),
    .vy        (in_vec_y),
    .vz        (in_vec_z),
    .rot       (rot),
    .valid_out (t_valid),
    .t_out     (t_mid)
  );

  // Second product t * conj(q), vector part saturated.
  qvr_qmul2 u_qmul2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (t_valid),
    .t_in      (t_mid),
    .rot       (rot),
    .valid_out (out_valid),
    .rx        (out_x),
    .ry        (out_y),
    .rz        (out_z)
  );

  // Every accepted request produces exactly one result.
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted request produced no result");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result without a matching request");

  a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
    t_valid |-> $past(accept, 2))
    else $error("first product valid without a request");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[3:2] == REG_W) |=> rot.w == $past(pwdata[QW-1:0]))
    else $error("scalar register write lost");

endmodule

`default_nettype wire

// File: tb/quaternion_vector_rotation_tb.sv
`timescale 1ns / 1ps

module quaternion_vector_rotation_tb;
  import qvr_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 103;
  localparam longint OutMax = 131071;
  localparam longint OutMin = -131072;

  // Expected or observed rotated vector.
  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
  } rot_vec_t;

  // One directed request: rotation preset, vector, and a typed-in answer where it is obvious.
  typedef struct {
    int qsel;
    int vx;
    int vy;
    int vz;
    bit typed;
    int ex;
    int ey;
    int ez;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [VecW-1:0] in_vec_x = '0;
  logic signed [VecW-1:0] in_vec_y = '0;
  logic signed [VecW-1:0] in_vec_z = '0;
  logic out_valid;
  logic signed [OutW-1:0] out_x;
  logic signed [OutW-1:0] out_y;
  logic signed [OutW-1:0] out_z;

  // Local copy of the rotation registers, updated as each write lands.
  quat_t rot_cfg;
  quat_t rot_presets [6];
  vec_row_t vec_rows [NumDirected];

  rot_vec_t pending_rot[$];
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int rotations_loaded = 0;
  int sat_hits = 0;
  bit no_gaps = 1'b0;

  quaternion_vector_rotation u_top (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .in_vec_x(in_vec_x),
    .in_vec_y(in_vec_y),
    .in_vec_z(in_vec_z),
    .out_valid(out_valid),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3000000;
    $display("Timed out with %0d results still pending.", pending_rot.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Divide by 2^14 with ties rounded toward plus infinity.
  function automatic longint round_half_up(longint a);
    return (a + 64'sd8192) >>> FracW;
  endfunction

  function automatic logic signed [OutW-1:0] clip_out(longint a);
    if (a > OutMax) begin
      return OutW'(OutMax);
    end
    if (a < OutMin) begin
      return OutW'(OutMin);
    end
    return OutW'(a);
  endfunction

  // Vector part of q * (0; v) * conj(q), rounded after each product.
  function automatic rot_vec_t rotate_expected(quat_t q, logic signed [VecW-1:0] vx,
                                               logic signed [VecW-1:0] vy,
                                               logic signed [VecW-1:0] vz);
    longint w, x, y, z, a, b, c, ts, tx, ty, tz;
    rot_vec_t r;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    a = vx;
    b = vy;
    c = vz;
    ts = round_half_up(-(x * a + y * b + z * c));
    tx = round_half_up(w * a + (y * c - z * b));
    ty = round_half_up(w * b + (z * a - x * c));
    tz = round_half_up(w * c + (x * b - y * a));
    r.x = clip_out(round_half_up(-ts * x + w * tx - (ty * z - tz * y)));
    r.y = clip_out(round_half_up(-ts * y + w * ty - (tz * x - tx * z)));
    r.z = clip_out(round_half_up(-ts * z + w * tz - (tx * y - ty * x)));
    return r;
  endfunction

  function automatic logic signed [QW-1:0] extreme_comp();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return '0;
    endcase
  endfunction

  // Random rotation: full range, moderate norm, signed axis, or extreme corners.
  function automatic quat_t rand_rotation();
    quat_t q;
    logic signed [QW-1:0] axis_val;
    q = '0;
    case ($urandom_range(0, 3))
      0: begin
        q.w = QW'($urandom);
        q.x = QW'($urandom);
        q.y = QW'($urandom);
        q.z = QW'($urandom);
      end
      1: begin
        q.w = QW'($urandom_range(0, 18000) - 9000);
        q.x = QW'($urandom_range(0, 18000) - 9000);
        q.y = QW'($urandom_range(0, 18000) - 9000);
        q.z = QW'($urandom_range(0, 18000) - 9000);
      end
      2: begin
        axis_val = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        case ($urandom_range(0, 3))
          0: q.w = axis_val;
          1: q.x = axis_val;
          2: q.y = axis_val;
          default: q.z = axis_val;
        endcase
      end
      default: begin
        q.w = extreme_comp();
        q.x = extreme_comp();
        q.y = extreme_comp();
        q.z = extreme_comp();
      end
    endcase
    return q;
  endfunction

  // Vector component: mostly full range, with small values and corners mixed in.
  function automatic logic signed [VecW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd1;
          3: return -16'sd1;
          default: return '0;
        endcase
      end
      1, 2: return VecW'($urandom_range(0, 512) - 256);
      default: return VecW'($urandom);
    endcase
  endfunction

  // Register write with a setup and an access cycle; upper data bits carry noise.
  task automatic apb_write(reg_idx_t idx, logic signed [QW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_W: rot_cfg.w = value;
      REG_X: rot_cfg.x = value;
      REG_Y: rot_cfg.y = value;
      default: rot_cfg.z = value;
    endcase
  endtask

  // Hold off new requests until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_rotation(quat_t q);
    drain_results();
    apb_write(REG_W, q.w);
    apb_write(REG_X, q.x);
    apb_write(REG_Y, q.y);
    apb_write(REG_Z, q.z);
    rotations_loaded++;
  endtask

  // Issue one request after a random gap and record its expected result.
  task automatic send_vec(logic signed [VecW-1:0] vx, logic signed [VecW-1:0] vy,
                          logic signed [VecW-1:0] vz, rot_vec_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    in_vec_z <= vz;
    do @(posedge clk); while (busy);
    pending_rot.push_back(want);
    requests_sent++;
    if (want.x == OutW'(OutMax) || want.x == OutW'(OutMin) ||
        want.y == OutW'(OutMax) || want.y == OutW'(OutMin) ||
        want.z == OutW'(OutMax) || want.z == OutW'(OutMin)) begin
      sat_hits++;
    end
  endtask

  task automatic report_mismatch(string what, rot_vec_t want, rot_vec_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)", what, $realtime,
               want.x, want.y, want.z, got.x, got.y, got.z);
    end
  endtask

  // Compare each result with the oldest pending expectation.
  always @(posedge clk) begin
    rot_vec_t got;
    rot_vec_t want;
    if (rst_n && out_valid) begin
      got.x = out_x;
      got.y = out_y;
      got.z = out_z;
      results_seen++;
      if (pending_rot.size() == 0) begin
        report_mismatch("Unexpected result", '0, got);
      end else begin
        want = pending_rot.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          report_mismatch("Result mismatch", want, got);
        end
      end
    end
  end

  initial begin
    rot_vec_t want;
    quat_t q;
    logic signed [VecW-1:0] vx, vy, vz;

    rot_cfg.w = ROT_W_RST;
    rot_cfg.x = ROT_V_RST;
    rot_cfg.y = ROT_V_RST;
    rot_cfg.z = ROT_V_RST;

    // Identity, half turn about x, all max, all min, quarter turn about z, negated identity.
    rot_presets[0] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    rot_presets[1] = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    rot_presets[2] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    rot_presets[3] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    rot_presets[4] = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
    rot_presets[5] = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0};

    // Rows on the reset rotation run before any register write.
    vec_rows = '{
      '{0, 0, 0, 0, 1, 0, 0, 0},
      '{0, 32767, 32767, 32767, 1, 32767, 32767, 32767},
      '{0, -32768, -32768, -32768, 1, -32768, -32768, -32768},
      '{0, 1, -1, 0, 1, 1, -1, 0},
      '{0, 32767, -32768, 1, 1, 32767, -32768, 1},
      '{1, 32767, 32767, 32767, 1, 32767, -32767, -32767},
      '{1, -32768, -32768, -32768, 1, -32768, 32768, 32768},
      '{1, 100, -200, 300, 1, 100, 200, -300},
      '{5, -32768, 32767, -1, 1, -32768, 32767, -1},
      '{5, 12345, -23456, 7, 1, 12345, -23456, 7},
      '{2, 32767, 32767, 32767, 0, 0, 0, 0},
      '{2, -32768, 32767, -32768, 0, 0, 0, 0},
      '{2, 1, 0, 0, 0, 0, 0, 0},
      '{3, 32767, 32767, 32767, 0, 0, 0, 0},
      '{3, -32768, -32768, -32768, 0, 0, 0, 0},
      '{3, 0, -1, 1, 0, 0, 0, 0},
      '{4, 16384, 0, 0, 0, 0, 0, 0},
      '{4, 0, 16384, 0, 0, 0, 0, 0},
      '{4, -32768, 32767, 0, 0, 0, 0, 0},
      '{4, 32767, -32768, 32767, 0, 0, 0, 0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; a rotation is loaded whenever the preset changes.
    for (int i = 0; i < NumDirected; i++) begin
      if (i != 0 && vec_rows[i].qsel != vec_rows[i-1].qsel) begin
        load_rotation(rot_presets[vec_rows[i].qsel]);
      end
      vx = VecW'(vec_rows[i].vx);
      vy = VecW'(vec_rows[i].vy);
      vz = VecW'(vec_rows[i].vz);
      if (vec_rows[i].typed) begin
        want.x = OutW'(vec_rows[i].ex);
        want.y = OutW'(vec_rows[i].ey);
        want.z = OutW'(vec_rows[i].ez);
      end else begin
        want = rotate_expected(rot_cfg, vx, vy, vz);
      end
      send_vec(vx, vy, vz, want);
    end

    // Random phases: corner rotations first, then random ones.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: q = rot_presets[3];
        1: q = rot_presets[2];
        default: q = rand_rotation();
      endcase
      load_rotation(q);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (k % 32 == 0) begin
          no_gaps = ($urandom_range(0, 3) == 0);
        end
        vx = rand_comp();
        vy = rand_comp();
        vz = rand_comp();
        send_vec(vx, vy, vz, rotate_expected(rot_cfg, vx, vy, vz));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_rot.size() != 0) begin
      mismatches += pending_rot.size();
      $display("%0d expected results never arrived.", pending_rot.size());
    end

    $display("Rotated %0d vectors under %0d register settings plus reset; %0d results checked.",
             requests_sent, rotations_loaded, results_seen);
    $display("%0d results had a saturated component; %0d mismatches.", sat_hits, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
